// ===== hdl/srse_pkg.sv =====
// ----------------------------------------------------------------------------
// srse_pkg
// Shared types and constants for the scanline run segment extractor.
// ----------------------------------------------------------------------------
package srse_pkg;

    // Row width after reset, truncated to the column width at the top level.
    localparam int unsigned ROW_WIDTH_RESET = 64;

    // Row record queue status, seen by the front (full) and back (empty).
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== hdl/scanline_run_segment_extractor.sv =====
// ----------------------------------------------------------------------------
// scanline_run_segment_extractor
// Finds runs of set pixels per bitmap row and emits their column pairs.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall / i_pixel): one pixel per item, rows sent
//   left to right, row_width pixels per row. Up to one pixel per cycle.
//   Output channel (o_valid / i_stall / segment fields): after a row's last
//   pixel, MAX_SEGS items follow, one per cycle unless stalled, the last
//   with o_row_done set. With the back end idle, the last pixel's record is
//   queued, then its first slot is registered at the output, raising o_valid.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): sets row_width;
//   write only while the block is idle. o_cfg_ready is always high.
//   Throughput: pixels inside a row go at one per cycle. A row end needs a
//   free slot in the two-row record queue; the back end drains a row as
//   MAX_SEGS items, so rows shorter than MAX_SEGS pixels are paced by the
//   back end. o_stall rises only at the last column with the queue full.
//   Reset: row_width returns to 64, the row position and queue clear.
//   A stalled receiver holds the output register; pixels keep flowing until
//   the queue fills at a row end.
// ----------------------------------------------------------------------------
module scanline_run_segment_extractor #(
    parameter int MAX_SEGS = 5,
    parameter int COL_BITS = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [COL_BITS-1:0] i_cfg_data,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_pixel,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [COL_BITS-1:0] o_seg_left,
    output logic [COL_BITS-1:0] o_seg_right,
    output logic                o_too_curvy,
    output logic                o_row_done
);
    import srse_pkg::*;

    localparam int REC_W = 2 * MAX_SEGS * COL_BITS + 1;

    logic [COL_BITS-1:0] r_row_width;
    logic                push, pop;
    logic [REC_W-1:0]    wr_rec, rd_rec;
    t_q_stat             q_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= COL_BITS'(ROW_WIDTH_RESET);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_row_width <= i_cfg_data;
        end
    end

    srse_front #(
        .MAX_SEGS (MAX_SEGS),
        .COL_BITS (COL_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_row_width (r_row_width),
        .i_valid     (i_valid),
        .i_pixel     (i_pixel),
        .o_stall     (o_stall),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_rec       (wr_rec)
    );

    srse_queue #(
        .REC_W (REC_W)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_wr_rec (wr_rec),
        .i_pop    (pop),
        .o_rd_rec (rd_rec),
        .o_stat   (q_stat)
    );

    srse_back #(
        .MAX_SEGS (MAX_SEGS),
        .COL_BITS (COL_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec       (rd_rec),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_seg_left  (o_seg_left),
        .o_seg_right (o_seg_right),
        .o_too_curvy (o_too_curvy),
        .o_row_done  (o_row_done)
    );

    // a row record is never written into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_stat.full)
        else $error("row record pushed into full queue");

    // the back end never retires a record that is not there
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("row record popped from empty queue");

    // a row's items come out without gaps once started
    a_row_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_row_done) |=> o_valid)
        else $error("gap inside a row's segment burst");

endmodule

// ===== hdl/srse_front.sv =====
// ----------------------------------------------------------------------------
// srse_front
// Pixel front end: tracks column and runs, builds one row record per row.
// ----------------------------------------------------------------------------
module srse_front #(
    parameter int MAX_SEGS = 5,
    parameter int COL_BITS = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [COL_BITS-1:0]                 i_row_width,
    input  logic                                i_valid,
    input  logic                                i_pixel,
    output logic                                o_stall,
    input  srse_pkg::t_q_stat                   i_q_stat,
    output logic                                o_push,
    output logic [2*MAX_SEGS*COL_BITS:0]        o_rec
);
    import srse_pkg::*;

    localparam int RUN_W = $clog2(MAX_SEGS + 1);
    localparam int PAIR_W = 2 * COL_BITS;

    logic [COL_BITS-1:0] r_column, n_column;
    logic [RUN_W-1:0]    r_runs, n_runs;
    logic                r_inside, n_inside;
    logic                r_ovf, n_ovf;
    logic [COL_BITS-1:0] r_left  [MAX_SEGS];
    logic [COL_BITS-1:0] r_right [MAX_SEGS];
    logic [COL_BITS-1:0] n_left  [MAX_SEGS];
    logic [COL_BITS-1:0] n_right [MAX_SEGS];

    logic [COL_BITS-1:0] w;
    logic                at_last;
    logic                accept;
    logic [RUN_W-1:0]    e_runs;
    logic                e_inside;
    logic                e_ovf;
    logic [COL_BITS-1:0] last_l, last_r, half;

    assign w       = (i_row_width == '0) ? COL_BITS'(1) : i_row_width;
    assign at_last = (r_column >= (w - COL_BITS'(1)));
    assign o_stall = i_q_stat.full && at_last;
    assign accept  = i_valid && !o_stall;
    assign half    = w >> 1;

    always_comb begin
        n_column = r_column;
        n_runs   = r_runs;
        n_inside = r_inside;
        n_ovf    = r_ovf;
        n_left   = r_left;
        n_right  = r_right;
        e_runs   = r_runs;
        e_inside = r_inside;
        e_ovf    = r_ovf;
        last_l   = '0;
        last_r   = '0;
        o_push   = 1'b0;
        o_rec    = '0;

        if (accept) begin
            if (i_pixel && !r_inside) begin
                if (r_runs < RUN_W'(MAX_SEGS)) begin
                    for (int k = 0; k < MAX_SEGS; k++) begin
                        if (r_runs == RUN_W'(k)) begin
                            n_left[k] = r_column;
                        end
                    end
                    e_inside = 1'b1;
                end else begin
                    e_ovf = 1'b1;
                end
            end else if (!i_pixel && r_inside) begin
                if (r_runs < RUN_W'(MAX_SEGS)) begin
                    for (int k = 0; k < MAX_SEGS; k++) begin
                        if (r_runs == RUN_W'(k)) begin
                            n_right[k] = r_column;
                        end
                    end
                    e_runs = r_runs + RUN_W'(1);
                end
                e_inside = 1'b0;
            end

            if (!at_last) begin
                n_column = r_column + COL_BITS'(1);
                n_runs   = e_runs;
                n_inside = e_inside;
                n_ovf    = e_ovf;
            end else begin
                // close a run that reaches the row edge
                if (e_inside && (e_runs < RUN_W'(MAX_SEGS))) begin
                    for (int k = 0; k < MAX_SEGS; k++) begin
                        if (e_runs == RUN_W'(k)) begin
                            n_right[k] = r_column + COL_BITS'(1);
                        end
                    end
                    e_runs = e_runs + RUN_W'(1);
                end

                for (int k = 0; k < MAX_SEGS; k++) begin
                    if (e_runs == RUN_W'(k + 1)) begin
                        last_l = n_left[k];
                        last_r = n_right[k];
                    end
                end

                // slots past the last run repeat it; blank row gives w/2
                for (int k = 0; k < MAX_SEGS; k++) begin
                    if (e_runs == '0) begin
                        o_rec[k*PAIR_W +: PAIR_W] = {half, half};
                    end else if (RUN_W'(k) < e_runs) begin
                        o_rec[k*PAIR_W +: PAIR_W] = {n_left[k], n_right[k]};
                    end else begin
                        o_rec[k*PAIR_W +: PAIR_W] = {last_l, last_r};
                    end
                end
                o_rec[MAX_SEGS*PAIR_W] = e_ovf;
                o_push   = 1'b1;

                n_column = '0;
                n_runs   = '0;
                n_inside = 1'b0;
                n_ovf    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column <= '0;
            r_runs   <= '0;
            r_inside <= 1'b0;
            r_ovf    <= 1'b0;
        end else begin
            r_column <= n_column;
            r_runs   <= n_runs;
            r_inside <= n_inside;
            r_ovf    <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left  <= n_left;
        r_right <= n_right;
    end

endmodule

// ===== hdl/srse_queue.sv =====
// ----------------------------------------------------------------------------
// srse_queue
// Two-entry queue of row records between the front and back ends.
// ----------------------------------------------------------------------------
module srse_queue #(
    parameter int REC_W = 101
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [REC_W-1:0]   i_wr_rec,
    input  logic               i_pop,
    output logic [REC_W-1:0]   o_rd_rec,
    output srse_pkg::t_q_stat  o_stat
);
    import srse_pkg::*;

    logic [REC_W-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;

    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);
    assign o_rd_rec     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_rec;
        end
    end

endmodule

// ===== hdl/srse_back.sv =====
// ----------------------------------------------------------------------------
// srse_back
// Back end: walks the head row record slot by slot into the output register.
// ----------------------------------------------------------------------------
module srse_back #(
    parameter int MAX_SEGS = 5,
    parameter int COL_BITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [2*MAX_SEGS*COL_BITS:0]  i_rec,
    input  srse_pkg::t_q_stat             i_q_stat,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [COL_BITS-1:0]           o_seg_left,
    output logic [COL_BITS-1:0]           o_seg_right,
    output logic                          o_too_curvy,
    output logic                          o_row_done
);
    import srse_pkg::*;

    localparam int SLOT_W = (MAX_SEGS > 1) ? $clog2(MAX_SEGS) : 1;
    localparam int PAIR_W = 2 * COL_BITS;

    logic [SLOT_W-1:0]   r_slot;
    logic                r_valid;
    logic [COL_BITS-1:0] r_seg_left, r_seg_right;
    logic                r_too_curvy, r_row_done;

    logic                load;
    logic                last_slot;
    logic [PAIR_W-1:0]   sel_pair;

    assign load      = !r_valid || !i_stall;
    assign last_slot = (r_slot == SLOT_W'(MAX_SEGS - 1));
    assign o_pop     = load && !i_q_stat.empty && last_slot;

    always_comb begin
        sel_pair = '0;
        for (int k = 0; k < MAX_SEGS; k++) begin
            if (r_slot == SLOT_W'(k)) begin
                sel_pair = i_rec[k*PAIR_W +: PAIR_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_slot  <= '0;
        end else if (load) begin
            r_valid <= !i_q_stat.empty;
            if (!i_q_stat.empty) begin
                r_slot <= last_slot ? '0 : r_slot + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && !i_q_stat.empty) begin
            r_seg_left  <= sel_pair[PAIR_W-1:COL_BITS];
            r_seg_right <= sel_pair[COL_BITS-1:0];
            r_too_curvy <= i_rec[MAX_SEGS*PAIR_W];
            r_row_done  <= last_slot;
        end
    end

    assign o_valid     = r_valid;
    assign o_seg_left  = r_seg_left;
    assign o_seg_right = r_seg_right;
    assign o_too_curvy = r_too_curvy;
    assign o_row_done  = r_row_done;

endmodule
